### hw/rtl/rpj_pkg.sv
// shared types and constants of the rigid 3d point jacobian block
package rpj_pkg;

  // quotient bits of the rotation rows, one bit per divider stage
  localparam int unsigned DivBits = 31;
  // register stages ahead of the divider
  localparam int unsigned PreStages = 4;
  // stages from an accepted beat to the last divider stage
  localparam int unsigned PipeDepth = PreStages + DivBits;

  typedef enum logic [2:0] {
    CfgQuatX  = 3'd0,
    CfgQuatY  = 3'd1,
    CfgQuatZ  = 3'd2,
    CfgQuatW  = 3'd3,
    CfgCenter = 3'd4,
    CfgTrans  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] point_z;
    logic signed [15:0] point_y;
    logic signed [15:0] point_x;
  } point_t;

  typedef struct packed {
    logic signed [31:0] jac_scale_z;
    logic signed [31:0] jac_scale_y;
    logic signed [31:0] jac_scale_x;
    logic signed [31:0] jac_qz_z;
    logic signed [31:0] jac_qz_y;
    logic signed [31:0] jac_qz_x;
    logic signed [31:0] jac_qy_z;
    logic signed [31:0] jac_qy_y;
    logic signed [31:0] jac_qy_x;
    logic signed [31:0] jac_qx_z;
    logic signed [31:0] jac_qx_y;
    logic signed [31:0] jac_qx_x;
  } result_t;

  // one divider lane stage: sign, overflow, partial remainder, dividend bits, quotient
  typedef struct packed {
    logic                 neg;
    logic                 ovf;
    logic [15:0]          rem;
    logic [DivBits-1:0]   lo;
    logic [DivBits-1:0]   quo;
  } div_t;

endpackage

### hw/rtl/rpj_div_lane.sv
// pipelined restoring divider lane, one quotient bit per stage, signed saturated result
module rpj_div_lane (
  input  logic              clk_i,
  input  rpj_pkg::div_t     div_i,
  input  logic [14:0]       den_i,
  output logic signed [31:0] quot_o
);

  rpj_pkg::div_t st_q [rpj_pkg::DivBits];
  rpj_pkg::div_t st_d [rpj_pkg::DivBits];

  function automatic rpj_pkg::div_t div_step(rpj_pkg::div_t s, logic [14:0] den);
    rpj_pkg::div_t r;
    logic [15:0]   sh;
    logic          ge;
    r   = s;
    sh  = {s.rem[14:0], s.lo[rpj_pkg::DivBits-1]};
    ge  = (sh >= {1'b0, den});
    r.rem = ge ? (sh - {1'b0, den}) : sh;
    r.lo  = {s.lo[rpj_pkg::DivBits-2:0], 1'b0};
    r.quo = {s.quo[rpj_pkg::DivBits-2:0], ge};
    return r;
  endfunction

  for (genvar k = 0; k < rpj_pkg::DivBits; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign st_d[k] = div_step(div_i, den_i);
    end else begin : g_next
      assign st_d[k] = div_step(st_q[k-1], den_i);
    end
    always_ff @(posedge clk_i) begin
      st_q[k] <= st_d[k];
    end
  end

  // quotient below 2^31 unless flagged, so negation cannot wrap
  always_comb begin
    if (st_q[rpj_pkg::DivBits-1].ovf) begin
      quot_o = st_q[rpj_pkg::DivBits-1].neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else if (st_q[rpj_pkg::DivBits-1].neg) begin
      quot_o = -$signed({1'b0, st_q[rpj_pkg::DivBits-1].quo});
    end else begin
      quot_o = $signed({1'b0, st_q[rpj_pkg::DivBits-1].quo});
    end
  end

endmodule

### hw/rtl/rigid3d_point_jacobian_top.sv
// top level of the rigid 3d point jacobian pipeline
// usage
//   input beats: a point (x, y, z, signed q12.4) is taken at each rising edge
//   with start high and busy low. busy is always low, so a point may enter
//   in every cycle.
//   result beats: the 4x3 jacobian (three rotation rows, one scale row, all
//   signed q20.12 saturated) appears on result_o for one cycle with
//   result_valid_o high. the receiver cannot stall, so nothing is held back.
//   configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i at once;
//   write only while no beat is in flight. the coefficient register stage
//   settles in the cycle after a write. the scale register cancels in every
//   output and is not stored.
// pipeline and throughput
//   a beat passes four arithmetic stages (offset, products, sums, magnitude
//   and rounding prep, the first loaded at the accepting edge), then a
//   31-stage restoring divider by the quaternion w (one quotient bit per
//   stage), then the output register, where result_valid_o rises.
//   one beat per cycle sustained.
// reset
//   rst_ni clears valid bits and loads the identity rotation (w = 1.0),
//   zero center and zero translation. no clearing pass is needed.
module rigid3d_point_jacobian_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  rpj_pkg::point_t  point_i,
  output logic             result_valid_o,
  output rpj_pkg::result_t result_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [47:0]      cfg_data_i
);

  // configuration registers
  logic signed [15:0] quat_x_q, quat_y_q, quat_z_q;
  logic [14:0]        quat_w_q;
  logic [47:0]        center_q, trans_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_x_q <= '0;
      quat_y_q <= '0;
      quat_z_q <= '0;
      quat_w_q <= 15'h4000;
      center_q <= '0;
      trans_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (rpj_pkg::cfg_idx_e'(cfg_idx_i))
        rpj_pkg::CfgQuatX:  quat_x_q <= cfg_data_i[15:0];
        rpj_pkg::CfgQuatY:  quat_y_q <= cfg_data_i[15:0];
        rpj_pkg::CfgQuatZ:  quat_z_q <= cfg_data_i[15:0];
        rpj_pkg::CfgQuatW:  quat_w_q <= cfg_data_i[14:0];
        rpj_pkg::CfgCenter: center_q <= cfg_data_i;
        rpj_pkg::CfgTrans:  trans_q  <= cfg_data_i;
        default: ;  // scale and unknown indexes are dropped
      endcase
    end
  end

  assign busy = 1'b0;

  // zero w is replaced by one lsb
  logic [14:0]        w_eff;
  logic signed [15:0] ws;
  assign w_eff = (quat_w_q == '0) ? 15'd1 : quat_w_q;
  assign ws    = $signed({1'b0, w_eff});

  // coefficient stage: bilinear forms of the quaternion, refreshed every cycle
  logic signed [31:0] xx, yy, zz, ww, xy, xz, xw, yz, yw, zw;
  logic signed [32:0] c_a, c_b, c_c, c_f, c_g, c_h, c_k, c_l, c_n, c_n2xw, c_n2yw, c_n2zw;
  logic signed [32:0] k_d [9][3];
  logic signed [32:0] k_q [9][3];

  always_comb begin
    xx = quat_x_q * quat_x_q;
    yy = quat_y_q * quat_y_q;
    zz = quat_z_q * quat_z_q;
    ww = ws * ws;
    xy = quat_x_q * quat_y_q;
    xz = quat_x_q * quat_z_q;
    xw = quat_x_q * ws;
    yz = quat_y_q * quat_z_q;
    yw = quat_y_q * ws;
    zw = quat_z_q * ws;
    c_a    = 33'(yw) + 33'(xz);
    c_b    = 33'(zw) - 33'(xy);
    c_c    = 33'(yw) - 33'(xz);
    c_f    = 33'(xx) - 33'(ww);
    c_g    = 33'(zw) + 33'(xy);
    c_h    = 33'(xw) + 33'(yz);
    c_k    = 33'(ww) - 33'(yy);
    c_l    = 33'(xw) - 33'(yz);
    c_n    = 33'(zz) - 33'(ww);
    c_n2xw = -(33'(xw) + 33'(xw));
    c_n2yw = -(33'(yw) + 33'(yw));
    c_n2zw = -(33'(zw) + 33'(zw));
    k_d[0] = '{33'sd0, c_a,    c_b};
    k_d[1] = '{c_c,    c_n2xw, c_f};
    k_d[2] = '{c_g,    -c_f,   c_n2xw};
    k_d[3] = '{c_n2yw, c_h,    c_k};
    k_d[4] = '{c_l,    33'sd0, c_g};
    k_d[5] = '{-c_k,   c_b,    c_n2yw};
    k_d[6] = '{c_n2zw, c_n,    c_l};
    k_d[7] = '{-c_n,   c_n2zw, c_a};
    k_d[8] = '{c_h,    c_c,    33'sd0};
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d;
  end

  // valid bits, one per stage up to the last divider stage
  logic [rpj_pkg::PipeDepth-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[rpj_pkg::PipeDepth-2:0], start & ~busy};
    end
  end

  // stage 1: offset from center, point plus translation
  logic signed [16:0] d1_q [3];
  logic signed [16:0] pt1_q [3];
  logic signed [15:0] pin [3];
  assign pin = '{point_i.point_x, point_i.point_y, point_i.point_z};

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      d1_q[i]  <= 17'(pin[i]) - 17'($signed(center_q[16*i +: 16]));
      pt1_q[i] <= 17'(pin[i]) + 17'($signed(trans_q[16*i +: 16]));
    end
  end

  // stage 2: coefficient times offset, cross product terms
  logic signed [49:0] prod2_q [9][3];
  logic signed [32:0] cr2_q [6];
  logic signed [16:0] pt2_q [3];

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 9; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod2_q[r][c] <= k_q[r][c] * d1_q[c];
      end
    end
    cr2_q[0] <= quat_y_q * d1_q[2];
    cr2_q[1] <= quat_z_q * d1_q[1];
    cr2_q[2] <= quat_z_q * d1_q[0];
    cr2_q[3] <= quat_x_q * d1_q[2];
    cr2_q[4] <= quat_x_q * d1_q[1];
    cr2_q[5] <= quat_y_q * d1_q[0];
    pt2_q    <= pt1_q;
  end

  // stage 3: row sums, u = 2 (q x d)
  logic signed [52:0] s3_q [9];
  logic signed [34:0] u3_q [3];
  logic signed [16:0] pt3_q [3];

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 9; r++) begin
      s3_q[r] <= 53'(prod2_q[r][0]) + 53'(prod2_q[r][1]) + 53'(prod2_q[r][2]);
    end
    for (int i = 0; i < 3; i++) begin
      u3_q[i] <= (35'(cr2_q[2*i]) - 35'(cr2_q[2*i+1])) <<< 1;
    end
    pt3_q <= pt2_q;
  end

  // stage 4: divider setup (rounded magnitude over 32, overflow check); w*u and q x u
  rpj_pkg::div_t      div4_d [9];
  rpj_pkg::div_t      div4_q [9];
  logic signed [50:0] wu4_q [3];
  logic signed [50:0] pa4_q [3];
  logic signed [50:0] pb4_q [3];
  logic signed [16:0] pt4_q [3];

  always_comb begin
    logic [52:0] mag;
    logic [52:0] m;
    for (int r = 0; r < 9; r++) begin
      mag            = s3_q[r][52] ? 53'(-s3_q[r]) : 53'(s3_q[r]);
      m              = mag + {34'd0, w_eff, 4'd0};
      div4_d[r].neg  = s3_q[r][52];
      div4_d[r].ovf  = (m[52:36] >= {2'b00, w_eff});
      div4_d[r].rem  = m[51:36];
      div4_d[r].lo   = m[35:5];
      div4_d[r].quo  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    div4_q <= div4_d;
    for (int i = 0; i < 3; i++) begin
      wu4_q[i] <= ws * u3_q[i];
    end
    pa4_q[0] <= quat_y_q * u3_q[2];
    pb4_q[0] <= quat_z_q * u3_q[1];
    pa4_q[1] <= quat_z_q * u3_q[0];
    pb4_q[1] <= quat_x_q * u3_q[2];
    pa4_q[2] <= quat_x_q * u3_q[1];
    pb4_q[2] <= quat_y_q * u3_q[0];
    pt4_q    <= pt3_q;
  end

  // stage 5: scale row sum, round by 2^20 ties away from zero, saturate
  function automatic logic signed [31:0] sat32(logic signed [33:0] v);
    if (v > 34'sh0_7fff_ffff) begin
      return 32'sh7fff_ffff;
    end else if (v < -34'sh0_8000_0000) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  logic signed [31:0] row3_d [3];

  always_comb begin
    logic signed [53:0] v;
    logic signed [53:0] vr;
    for (int i = 0; i < 3; i++) begin
      v  = 54'(wu4_q[i]) + 54'(pa4_q[i]) - 54'(pb4_q[i]) + (54'(pt4_q[i]) <<< 28);
      vr = v + (v[53] ? 54'sd524287 : 54'sd524288);
      row3_d[i] = sat32(34'(vr >>> 20));
    end
  end

  // scale row waits alongside the divider
  logic signed [31:0] dly_q [rpj_pkg::DivBits][3];

  always_ff @(posedge clk_i) begin
    dly_q[0] <= row3_d;
    for (int k = 1; k < rpj_pkg::DivBits; k++) begin
      dly_q[k] <= dly_q[k-1];
    end
  end

  // rotation rows: one divider lane per entry
  logic signed [31:0] quot [9];

  for (genvar r = 0; r < 9; r++) begin : g_lane
    rpj_div_lane u_div (
      .clk_i  (clk_i),
      .div_i  (div4_q[r]),
      .den_i  (w_eff),
      .quot_o (quot[r])
    );
  end

  // output register
  logic             res_vld_q;
  rpj_pkg::result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= vld_q[rpj_pkg::PipeDepth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.jac_qx_x    <= quot[0];
    res_q.jac_qx_y    <= quot[1];
    res_q.jac_qx_z    <= quot[2];
    res_q.jac_qy_x    <= quot[3];
    res_q.jac_qy_y    <= quot[4];
    res_q.jac_qy_z    <= quot[5];
    res_q.jac_qz_x    <= quot[6];
    res_q.jac_qz_y    <= quot[7];
    res_q.jac_qz_z    <= quot[8];
    res_q.jac_scale_x <= dly_q[rpj_pkg::DivBits-1][0];
    res_q.jac_scale_y <= dly_q[rpj_pkg::DivBits-1][1];
    res_q.jac_scale_z <= dly_q[rpj_pkg::DivBits-1][2];
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

endmodule
